// ===== sv/ffa_pkg.sv =====
// Package with the item types, status codes and sequencer states of the block allocator.
package ffa_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_REALLOC = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_ZERO      = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] request_size;
        logic [31:0] payload_address;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [31:0] block_bytes;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] size;
        logic        free;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LRD,
        S_LEV,
        S_ARD,
        S_AEV,
        S_APP,
        S_MRD,
        S_MEV,
        S_MFIN,
        S_DONE
    } state_t;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

endpackage

// ===== sv/ffa_mem.sv =====
// Block table memory: one write port and one registered read port.
module ffa_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output ffa_pkg::entry_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ffa_pkg::entry_t wr_data
);
    import ffa_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/ffa_ctrl.sv =====
// Sequencer that walks, updates and compacts the block table.
module ffa_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int IW           = 6,
    parameter int CW           = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffa_pkg::req_t   cmd,
    output logic            done,
    output ffa_pkg::rsp_t   result,
    input  logic [31:0]     heap_base,
    input  logic [31:0]     heap_limit,
    output logic            rd_en,
    output logic [IW-1:0]   rd_addr,
    input  ffa_pkg::entry_t rd_data,
    output logic            wr_en,
    output logic [IW-1:0]   wr_addr,
    output ffa_pkg::entry_t wr_data
);
    import ffa_pkg::*;

    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    state_t        state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [31:0]   req_reg, req_next;
    logic [31:0]   addr_reg, addr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   old_reg, old_next;
    logic [CW-1:0] i_reg, i_next;
    logic [33:0]   pos_reg, pos_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] w_reg, w_next;
    logic [31:0]   acc_size_reg, acc_size_next;
    logic          acc_free_reg, acc_free_next;
    logic          acc_valid_reg, acc_valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   brk_reg, brk_next;
    logic [31:0]   raddr_reg, raddr_next;
    logic [31:0]   rbytes_reg, rbytes_next;
    logic [2:0]    rstat_reg, rstat_next;

    logic          walk_end, merge_end, hit, fit, in_realloc, grow_bad, full;
    logic [34:0]   nb;
    logic [33:0]   pos_start, pos_step;
    logic          cur_free;

    assign walk_end   = (i_reg == count_reg);
    assign merge_end  = (j_reg == count_reg);
    assign hit        = (pos_reg == {2'b00, addr_reg});
    assign fit        = rd_data.free && (rd_data.size >= req_reg);
    assign in_realloc = (mode_reg == MODE_REALLOC) && (addr_reg != 32'd0);
    assign nb         = {3'b000, brk_reg} + {3'b000, HDR} + {3'b000, req_reg};
    assign grow_bad   = (nb > {3'b000, heap_limit})
                        || (({3'b000, heap_base} + nb) > 35'h1_0000_0000);
    assign full       = (count_reg >= CW'(MAX_BLOCKS));
    assign pos_start  = {2'b00, heap_base} + {2'b00, HDR};
    assign pos_step   = pos_reg + {2'b00, rd_data.size} + {2'b00, HDR};
    assign cur_free   = rd_data.free || (j_reg == idx_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.mode)
                        MODE_ALLOC:
                            state_next = (cmd.request_size == 32'd0) ? S_DONE : S_ARD;
                        MODE_FREE:
                            state_next = (cmd.payload_address == 32'd0) ? S_DONE : S_LRD;
                        MODE_REALLOC:
                        begin
                            if (cmd.payload_address != 32'd0)
                                state_next = S_LRD;
                            else
                                state_next = (cmd.request_size == 32'd0) ? S_DONE : S_ARD;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_LRD:
                state_next = walk_end ? S_DONE : S_LEV;
            S_LEV:
            begin
                if (!hit)
                    state_next = S_LRD;
                else if (mode_reg == MODE_FREE)
                    state_next = S_MRD;
                else if (rd_data.free)
                    state_next = S_DONE;
                else if (req_reg == 32'd0)
                    state_next = S_MRD;
                else if (rd_data.size >= req_reg)
                    state_next = S_DONE;
                else
                    state_next = S_ARD;
            end
            S_ARD:
                state_next = walk_end ? S_APP : S_AEV;
            S_AEV:
                state_next = fit ? (in_realloc ? S_MRD : S_DONE) : S_ARD;
            S_APP:
                state_next = (!grow_bad && !full && in_realloc) ? S_MRD : S_DONE;
            S_MRD:
                state_next = merge_end ? S_MFIN : S_MEV;
            S_MEV:
                state_next = S_MRD;
            S_MFIN:
                state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        mode_next      = mode_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        old_next       = old_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        acc_size_next  = acc_size_reg;
        acc_free_next  = acc_free_reg;
        acc_valid_next = acc_valid_reg;
        count_next     = count_reg;
        brk_next       = brk_reg;
        raddr_next     = raddr_reg;
        rbytes_next    = rbytes_reg;
        rstat_next     = rstat_reg;
        rd_en          = 1'b0;
        rd_addr        = i_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = i_reg[IW-1:0];
        wr_data        = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next      = cmd.mode;
                    req_next       = cmd.request_size;
                    addr_next      = cmd.payload_address;
                    i_next         = '0;
                    j_next         = '0;
                    w_next         = '0;
                    acc_valid_next = 1'b0;
                    pos_next       = pos_start;
                    raddr_next     = 32'd0;
                    rbytes_next    = 32'd0;
                    rstat_next     = ST_OK;
                    if (cmd.request_size == 32'd0 && (cmd.mode == MODE_ALLOC
                        || (cmd.mode == MODE_REALLOC && cmd.payload_address == 32'd0)))
                        rstat_next = ST_ZERO;
                end
            end
            S_LRD:
            begin
                rd_en = !walk_end;
                if (walk_end)
                    rstat_next = ST_UNKNOWN;
            end
            S_LEV:
            begin
                if (!hit)
                begin
                    pos_next = pos_step;
                    i_next   = i_reg + 1'b1;
                end
                else
                begin
                    idx_next = i_reg;
                    if (mode_reg == MODE_REALLOC)
                    begin
                        if (rd_data.free)
                            rstat_next = ST_UNKNOWN;
                        else if (req_reg != 32'd0 && rd_data.size >= req_reg)
                        begin
                            raddr_next  = addr_reg;
                            rbytes_next = rd_data.size;
                        end
                        else if (req_reg != 32'd0)
                        begin
                            old_next = rd_data.size;
                            i_next   = '0;
                            pos_next = pos_start;
                        end
                    end
                end
            end
            S_ARD:
                rd_en = !walk_end;
            S_AEV:
            begin
                if (fit)
                begin
                    wr_en        = 1'b1;
                    wr_data.free = 1'b0;
                    raddr_next   = pos_reg[31:0];
                    rbytes_next  = rd_data.size;
                end
                else
                begin
                    pos_next = pos_step;
                    i_next   = i_reg + 1'b1;
                end
            end
            S_APP:
            begin
                if (grow_bad || full)
                begin
                    rstat_next  = grow_bad ? ST_EXHAUSTED : ST_FULL;
                    raddr_next  = 32'd0;
                    rbytes_next = in_realloc ? old_reg : 32'd0;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_addr      = count_reg[IW-1:0];
                    wr_data.size = req_reg;
                    wr_data.free = 1'b0;
                    raddr_next   = heap_base + brk_reg + HDR;
                    rbytes_next  = req_reg;
                    count_next   = count_reg + 1'b1;
                    brk_next     = nb[31:0];
                end
            end
            S_MRD:
            begin
                rd_en   = !merge_end;
                rd_addr = j_reg[IW-1:0];
            end
            S_MEV:
            begin
                // Runs of free blocks fold into the first one of the run.
                j_next = j_reg + 1'b1;
                if (acc_valid_reg && acc_free_reg && cur_free)
                    acc_size_next = acc_size_reg + HDR + rd_data.size;
                else
                begin
                    if (acc_valid_reg)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = w_reg[IW-1:0];
                        wr_data.size = acc_size_reg;
                        wr_data.free = acc_free_reg;
                        w_next       = w_reg + 1'b1;
                    end
                    acc_valid_next = 1'b1;
                    acc_size_next  = rd_data.size;
                    acc_free_next  = cur_free;
                end
            end
            S_MFIN:
            begin
                wr_en        = acc_valid_reg;
                wr_addr      = w_reg[IW-1:0];
                wr_data.size = acc_size_reg;
                wr_data.free = acc_free_reg;
                count_next   = acc_valid_reg ? w_reg + 1'b1 : w_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            brk_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            brk_reg   <= brk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        idx_reg       <= idx_next;
        old_reg       <= old_next;
        i_reg         <= i_next;
        pos_reg       <= pos_next;
        j_reg         <= j_next;
        w_reg         <= w_next;
        acc_size_reg  <= acc_size_next;
        acc_free_reg  <= acc_free_next;
        acc_valid_reg <= acc_valid_next;
        raddr_reg     <= raddr_next;
        rbytes_reg    <= rbytes_next;
        rstat_reg     <= rstat_next;
    end

    assign busy                  = (state_reg != S_IDLE);
    assign done                  = (state_reg == S_DONE);
    assign result.result_address = raddr_reg;
    assign result.block_bytes    = rbytes_reg;
    assign result.status         = rstat_reg;

endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator.
// An item (mode, request_size, payload_address) is taken on a rising edge with start
// high and busy low. busy then stays high until the result has been shown.
// The result sits on result for exactly one cycle with done high; the receiver
// cannot stall it, and busy falls in the cycle after done.
// A free walks the table to find the block and then makes a compaction pass over
// all entries; reallocate may add a first-fit search before that pass. Each table
// entry visited is read through the single read port of the block table memory
// and then evaluated.
// Configuration (heap_base at index 0, heap_limit at index 1) is written through
// cfg_valid/cfg_ready; cfg_ready is always high and writes belong to idle periods.
// Reset empties the table and the break and loads heap_base and heap_limit with
// 65536; table contents are not cleared, as only entries below the count are read.
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffa_pkg::req_t  cmd,
    output logic           done,
    output ffa_pkg::rsp_t  result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_data
);
    import ffa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [31:0]   heap_base_reg;
    logic [31:0]   heap_limit_reg;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= 32'd65536;
            heap_limit_reg <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_HEAP_BASE)
                heap_base_reg <= cfg_data;
            else
                heap_limit_reg <= cfg_data;
        end
    end

    ffa_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ffa_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .IW           (IW),
        .CW           (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .heap_base  (heap_base_reg),
        .heap_limit (heap_limit_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside a busy period");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

endmodule
